// ----- rtl/ocq_pkg.sv -----
// Package: operation and status codes, sequencer states and defaults for the ordered queue.
package ocq_pkg;

   localparam int DEF_QUEUE_DEPTH  = 16;
   localparam int DEF_NUMBER_WIDTH = 16;
   localparam int OP_W             = 2;
   localparam int FIELD_W          = 16;
   localparam int COUNT_W          = 5;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 2'd0,
      OP_POP    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_QUERY  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

endpackage

// ----- rtl/ocq_ram.sv -----
// Generic simple dual-port RAM with registered read.
module ocq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/ordered_queue_with_removal_core.sv -----
// Top level: ordered queue with append, pop, remove and search over one RAM.
//
//   channel  ports                                   handshake
//   req      req_operation, req_car_number           start && !busy
//   rsp      rsp_status .. rsp_entry_count           rsp_strobe, one cycle
//
// Append, and any operation on an empty queue: no scan, busy stays low.
// Pop, remove, query on a non-empty queue: busy scan; the RAM read port walks the
// entries one a cycle, shifted entries go back through the write port.
// Reset clears the count and sequencer; entries need no clearing.
// The receiver cannot stall; each result beat is shown for one cycle.
module ordered_queue_with_removal_core #(
   parameter int QUEUE_DEPTH  = ocq_pkg::DEF_QUEUE_DEPTH,
   parameter int NUMBER_WIDTH = ocq_pkg::DEF_NUMBER_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ocq_pkg::OP_W-1:0]      req_operation,
   input  logic [ocq_pkg::FIELD_W-1:0]   req_car_number,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_status,
   output logic [ocq_pkg::FIELD_W-1:0]   rsp_popped_number,
   output logic                          rsp_found,
   output logic                          rsp_head_valid,
   output logic [ocq_pkg::FIELD_W-1:0]   rsp_head_number,
   output logic [ocq_pkg::COUNT_W-1:0]   rsp_entry_count
);
   import ocq_pkg::*;

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int NW = NUMBER_WIDTH;

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [NW-1:0]    num_ff, num_in;
   logic [CW-1:0]    occ_ff, occ_in;
   logic [NW-1:0]    head_ff, head_in;
   logic [NW-1:0]    newhead_ff, newhead_in;
   logic [CW-1:0]    rd_cnt_ff, rd_cnt_in;
   logic             dv_ff, dv_in;
   logic [IW-1:0]    dat_idx_ff, dat_idx_in;
   logic             shift_ff, shift_in;
   logic             found_ff, found_in;
   logic             rm_head_ff, rm_head_in;

   logic             rsp_strobe_ff, rsp_strobe_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [NW-1:0]    rsp_popped_ff, rsp_popped_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [NW-1:0]    rsp_head_ff, rsp_head_in;
   logic [CW-1:0]    rsp_count_ff, rsp_count_in;

   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   logic [NW-1:0]    wr_data;
   logic [IW-1:0]    rd_addr;
   logic [NW-1:0]    rd_data;

   logic [NW-1:0]    req_num;
   op_type           req_op;
   logic             accept;
   logic             match;
   logic             found_now;
   logic             removed;
   logic             last;
   logic             rm_head_now;
   logic [NW-1:0]    head_next;
   logic [CW-1:0]    occ_next;

   assign req_num = NW'(req_car_number);
   assign req_op  = op_type'(req_operation);
   assign busy    = (state_ff == S_SCAN);
   assign accept  = start && !busy;

   ocq_ram #(.WIDTH(NW), .DEPTH(QUEUE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         occ_ff        <= '0;
         dv_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         dv_ff         <= dv_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      op_ff         <= op_in;
      num_ff        <= num_in;
      head_ff       <= head_in;
      newhead_ff    <= newhead_in;
      rd_cnt_ff     <= rd_cnt_in;
      dat_idx_ff    <= dat_idx_in;
      shift_ff      <= shift_in;
      found_ff      <= found_in;
      rm_head_ff    <= rm_head_in;
      rsp_status_ff <= rsp_status_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      num_in        = num_ff;
      occ_in        = occ_ff;
      head_in       = head_ff;
      newhead_in    = newhead_ff;
      rd_cnt_in     = rd_cnt_ff;
      dv_in         = 1'b0;
      dat_idx_in    = dat_idx_ff;
      shift_in      = shift_ff;
      found_in      = found_ff;
      rm_head_in    = rm_head_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_popped_in = rsp_popped_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_head_in   = rsp_head_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = occ_ff[IW-1:0];
      wr_data       = req_num;
      rd_addr       = rd_cnt_ff[IW-1:0];

      match       = dv_ff && !shift_ff && ((op_ff == OP_POP) || (rd_data == num_ff));
      found_now   = found_ff || match;
      removed     = found_now && (op_ff != OP_QUERY);
      last        = dv_ff && (CW'(dat_idx_ff) == occ_ff - 1'b1);
      rm_head_now = rm_head_ff || (match && (dat_idx_ff == '0));
      head_next   = (shift_ff && (dat_idx_ff == IW'(1))) ? rd_data : newhead_ff;
      occ_next    = removed ? occ_ff - 1'b1 : occ_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in         = req_op;
               num_in        = req_num;
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_OK;
               rsp_popped_in = '0;
               rsp_found_in  = 1'b0;
               rsp_head_in   = head_ff;
               rsp_count_in  = occ_ff;
               if (req_op == OP_APPEND) begin
                  if (occ_ff == CW'(QUEUE_DEPTH)) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     wr_en        = 1'b1;
                     occ_in       = occ_ff + 1'b1;
                     rsp_count_in = occ_ff + 1'b1;
                     if (occ_ff == '0) begin
                        head_in     = req_num;
                        rsp_head_in = req_num;
                     end
                  end
               end else if (occ_ff == '0) begin
                  if (req_op == OP_POP) begin
                     rsp_status_in = ST_EMPTY;
                  end else if (req_op == OP_REMOVE) begin
                     rsp_status_in = ST_NOT_FOUND;
                  end
               end else begin
                  rsp_strobe_in = 1'b0;
                  state_in      = S_SCAN;
                  rd_cnt_in     = '0;
                  shift_in      = 1'b0;
                  found_in      = 1'b0;
                  rm_head_in    = 1'b0;
               end
            end
         end
         S_SCAN: begin
            if (rd_cnt_ff < occ_ff) begin
               dv_in      = 1'b1;
               dat_idx_in = rd_cnt_ff[IW-1:0];
               rd_cnt_in  = rd_cnt_ff + 1'b1;
            end
            if (dv_ff) begin
               if (shift_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = dat_idx_ff - 1'b1;
                  wr_data = rd_data;
               end
               if (match) begin
                  found_in = 1'b1;
                  if (op_ff != OP_QUERY) begin
                     shift_in = 1'b1;
                  end
               end
               rm_head_in = rm_head_now;
               newhead_in = head_next;
            end
            if (last) begin
               state_in      = S_IDLE;
               dv_in         = 1'b0;
               occ_in        = occ_next;
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_OK;
               if ((op_ff == OP_REMOVE) && !found_now) begin
                  rsp_status_in = ST_NOT_FOUND;
               end
               rsp_popped_in = (op_ff == OP_POP) ? head_ff : '0;
               rsp_found_in  = found_now && (op_ff != OP_POP);
               rsp_count_in  = occ_next;
               if (removed && rm_head_now) begin
                  head_in     = head_next;
                  rsp_head_in = head_next;
               end else begin
                  rsp_head_in = head_ff;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_popped_number = FIELD_W'(rsp_popped_ff);
   assign rsp_found         = rsp_found_ff;
   assign rsp_head_valid    = (rsp_count_ff != '0);
   assign rsp_head_number   = (rsp_count_ff != '0) ? FIELD_W'(rsp_head_ff) : '0;
   assign rsp_entry_count   = COUNT_W'(rsp_count_ff);

`ifndef SYNTH
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(QUEUE_DEPTH))
      else $error("occupancy beyond depth");

   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      accept && (req_op != OP_APPEND) && (occ_ff != '0) |=> busy && !rsp_strobe)
      else $error("scan not entered");

   a_scan_result: assert property (@(posedge clock) disable iff (reset)
      busy && (state_in == S_IDLE) |=> rsp_strobe && !busy)
      else $error("scan ended without result");

   a_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == ST_NOT_FOUND) |-> !rsp_found)
      else $error("not found with found flag");
`endif

endmodule
